// ===== hw/rtl/zero_padded_2d_convolution_defines.svh =====
// Assertion macros for the zero padded 2D convolution block.
// Used by the top level; expects clk and arst_n in scope.
`ifndef ZERO_PADDED_2D_CONVOLUTION_DEFINES_SVH
`define ZERO_PADDED_2D_CONVOLUTION_DEFINES_SVH

// same-cycle implication
`define ZPC_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("zpc assertion failed");

// next-cycle implication
`define ZPC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("zpc assertion failed");

`endif

// ===== hw/rtl/zpc_pkg.sv =====
// Shared constants and controller/datapath interface types for the
// zero padded 2D convolution block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package zpc_pkg;
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;
	localparam int MAX_RADIUS = 3;
	localparam int SLOTS      = 2 * MAX_RADIUS + 1;
	localparam int KTAPS      = SLOTS * SLOTS;
	localparam int LS_DEPTH   = SLOTS * MAX_WIDTH;
	localparam int LS_AW      = $clog2(LS_DEPTH);
	localparam int SLOT_W     = $clog2(SLOTS);
	localparam int KOFF_W     = $clog2(SLOTS);
	localparam int KIDX_W     = 6;
	localparam int COL_W      = 10;
	localparam int ROW_W      = 12;
	localparam int WID_W      = 11;
	localparam int HGT_W      = 13;
	localparam int RAD_W      = 2;
	localparam int POS_W      = 14;
	localparam int PIX_W      = 16;
	localparam int COEF_W     = 18;
	localparam int PROD_W     = PIX_W + COEF_W;
	localparam int ACC_W      = 39;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd2;

	localparam logic ACT_COEF  = 1'b0;
	localparam logic ACT_PIXEL = 1'b1;

	typedef struct packed {
		logic tap_issue;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic win_any;
		logic tap_last;
		logic acc_done;
		logic out_free;
		logic win_last;
	} status_t;
endpackage

`default_nettype wire

// ===== hw/rtl/zpc_ctrl.sv =====
// Controller state machine: sequences taps and output windows.
// Depends on zpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module zpc_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_accept,
	input  wire                 action,
	input  zpc_pkg::status_t    status,
	output zpc_pkg::cmd_t       cmd,
	output logic                idle
);
	typedef enum logic [1:0] {ST_IDLE, ST_TAP, ST_WAIT} state_t;
	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept && action == zpc_pkg::ACT_PIXEL && status.win_any)
						state_q <= ST_TAP;
				end
				ST_TAP: begin
					if (status.tap_last) state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (status.acc_done && status.out_free)
						state_q <= status.win_last ? ST_IDLE : ST_TAP;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd.tap_issue = (state_q == ST_TAP);
		cmd.out_load  = (state_q == ST_WAIT) && status.acc_done && status.out_free;
		idle          = (state_q == ST_IDLE);
	end
endmodule

`default_nettype wire

// ===== hw/rtl/zpc_datapath.sv =====
// Datapath: config registers, position counters, line and coefficient
// memories, multiply-accumulate pipeline and output register. Uses zpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module zpc_datapath (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   in_accept,
	input  wire                                   action,
	input  wire [zpc_pkg::KIDX_W-1:0]             coef_index,
	input  wire signed [zpc_pkg::COEF_W-1:0]      coef_value,
	input  wire signed [zpc_pkg::PIX_W-1:0]       pixel_value,
	input  wire                                   cfg_we,
	input  wire [zpc_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  wire [zpc_pkg::CFG_DATA_W-1:0]         cfg_data,
	input  zpc_pkg::cmd_t                         cmd,
	output zpc_pkg::status_t                      status,
	output logic                                  out_valid,
	input  wire                                   out_ready,
	output logic signed [zpc_pkg::ACC_W-1:0]      filtered_value,
	output logic [zpc_pkg::COL_W-1:0]             out_column,
	output logic [zpc_pkg::ROW_W-1:0]             out_row,
	output logic                                  last
);
	logic [zpc_pkg::WID_W-1:0] width_q, w_eff;
	logic [zpc_pkg::HGT_W-1:0] height_q, h_eff;
	logic [zpc_pkg::RAD_W-1:0] radius_q, r_eff;
	logic [zpc_pkg::KOFF_W-1:0] side_m1;
	logic [zpc_pkg::KIDX_W-1:0] ksq;

	logic [zpc_pkg::COL_W-1:0]  col_q, px;
	logic [zpc_pkg::ROW_W-1:0]  row_q, py;
	logic [zpc_pkg::SLOT_W-1:0] slot_q, pslot;
	logic last_col, last_row, x_ok, y_ok, pix_accept;

	logic [zpc_pkg::ROW_W-1:0]  ctx_py_q, oy_q, oy_hi_q;
	logic [zpc_pkg::SLOT_W-1:0] ctx_slot_q;
	logic [zpc_pkg::COL_W-1:0]  ox_q, ox_lo_q, ox_hi_q;
	logic [zpc_pkg::KOFF_W-1:0] kyi_q, kxi_q;
	logic [zpc_pkg::KIDX_W-1:0] k_q;

	logic signed [zpc_pkg::PIX_W-1:0]  ls_mem [zpc_pkg::LS_DEPTH];
	logic signed [zpc_pkg::COEF_W-1:0] cf_mem [zpc_pkg::KTAPS];
	logic [zpc_pkg::KTAPS-1:0]         cf_vld_q;

	logic signed [zpc_pkg::POS_W-1:0] ty, tx, dd;
	logic [zpc_pkg::SLOT_W:0]         sl4;
	logic [zpc_pkg::SLOT_W-1:0]       rd_slot;
	logic [zpc_pkg::LS_AW-1:0]        rd_addr, wr_addr;
	logic tap_ok, tap_last;

	logic vld_s1, last_s1, ok_s1, cvld_s1;
	logic signed [zpc_pkg::PIX_W-1:0]  pix_s1;
	logic signed [zpc_pkg::COEF_W-1:0] coef_s1;
	logic vld_s2, last_s2;
	logic signed [zpc_pkg::PROD_W-1:0] prod_s2;
	logic signed [zpc_pkg::ACC_W-1:0]  acc_q;
	logic acc_done_q, out_valid_q, win_last;

	always_comb begin
		if (width_q == '0) w_eff = zpc_pkg::WID_W'(1);
		else if (width_q > zpc_pkg::WID_W'(zpc_pkg::MAX_WIDTH))
			w_eff = zpc_pkg::WID_W'(zpc_pkg::MAX_WIDTH);
		else w_eff = width_q;
		if (height_q == '0) h_eff = zpc_pkg::HGT_W'(1);
		else if (height_q > zpc_pkg::HGT_W'(zpc_pkg::MAX_HEIGHT))
			h_eff = zpc_pkg::HGT_W'(zpc_pkg::MAX_HEIGHT);
		else h_eff = height_q;
		r_eff = (radius_q > zpc_pkg::RAD_W'(zpc_pkg::MAX_RADIUS)) ?
			zpc_pkg::RAD_W'(zpc_pkg::MAX_RADIUS) : radius_q;
		side_m1 = zpc_pkg::KOFF_W'({r_eff, 1'b0});
		ksq = zpc_pkg::KIDX_W'(side_m1 + 1'b1) * zpc_pkg::KIDX_W'(side_m1 + 1'b1);
	end

	// current pixel position
	always_comb begin
		pix_accept = in_accept && action == zpc_pkg::ACT_PIXEL;
		px = ({1'b0, col_q} >= w_eff) ? '0 : col_q;
		py = ({1'b0, row_q} >= h_eff) ? '0 : row_q;
		pslot = ({1'b0, row_q} >= h_eff) ? '0 : slot_q;
		last_col = ({1'b0, px} == w_eff - 1'b1);
		last_row = ({1'b0, py} == h_eff - 1'b1);
		x_ok = (px >= zpc_pkg::COL_W'(r_eff)) || last_col;
		y_ok = (py >= zpc_pkg::ROW_W'(r_eff)) || last_row;
		wr_addr = zpc_pkg::LS_AW'(pslot * zpc_pkg::MAX_WIDTH) + zpc_pkg::LS_AW'(px);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= zpc_pkg::WID_W'(1024);
			height_q <= zpc_pkg::HGT_W'(1024);
			radius_q <= zpc_pkg::RAD_W'(1);
			col_q    <= '0;
			row_q    <= '0;
			slot_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				zpc_pkg::REG_WIDTH:  width_q  <= cfg_data[zpc_pkg::WID_W-1:0];
				zpc_pkg::REG_HEIGHT: height_q <= cfg_data;
				zpc_pkg::REG_RADIUS: radius_q <= cfg_data[zpc_pkg::RAD_W-1:0];
				default: ;
			endcase
			if (cfg_index == zpc_pkg::REG_WIDTH || cfg_index == zpc_pkg::REG_HEIGHT ||
				cfg_index == zpc_pkg::REG_RADIUS) begin
				col_q  <= '0;
				row_q  <= '0;
				slot_q <= '0;
			end
		end else if (pix_accept) begin
			if (last_col) begin
				col_q  <= '0;
				row_q  <= last_row ? '0 : py + 1'b1;
				slot_q <= (last_row || pslot == zpc_pkg::SLOT_W'(zpc_pkg::SLOTS - 1)) ?
					'0 : pslot + 1'b1;
			end else begin
				col_q  <= px + 1'b1;
				row_q  <= py;
				slot_q <= pslot;
			end
		end
	end

	// tap address
	always_comb begin
		ty = $signed({2'b0, oy_q}) + $signed(zpc_pkg::POS_W'(kyi_q))
			- $signed(zpc_pkg::POS_W'(r_eff));
		tx = $signed({4'b0, ox_q}) + $signed(zpc_pkg::POS_W'(kxi_q))
			- $signed(zpc_pkg::POS_W'(r_eff));
		tap_ok = !ty[zpc_pkg::POS_W-1] && ty < $signed({1'b0, h_eff})
			&& !tx[zpc_pkg::POS_W-1] && tx < $signed({3'b0, w_eff});
		dd = $signed({2'b0, ctx_py_q}) - ty;
		sl4 = {1'b0, ctx_slot_q} - {1'b0, dd[zpc_pkg::SLOT_W-1:0]};
		rd_slot = sl4[zpc_pkg::SLOT_W] ?
			sl4[zpc_pkg::SLOT_W-1:0] + zpc_pkg::SLOT_W'(zpc_pkg::SLOTS) :
			sl4[zpc_pkg::SLOT_W-1:0];
		rd_addr = zpc_pkg::LS_AW'(rd_slot * zpc_pkg::MAX_WIDTH)
			+ zpc_pkg::LS_AW'(tx[zpc_pkg::COL_W-1:0]);
		tap_last = (kxi_q == side_m1) && (kyi_q == side_m1);
		win_last = (ox_q == ox_hi_q) && (oy_q == oy_hi_q);
	end

	always_ff @(posedge clk) begin
		if (pix_accept) ls_mem[wr_addr] <= pixel_value;
		pix_s1 <= ls_mem[rd_addr];
		if (in_accept && action == zpc_pkg::ACT_COEF && coef_index < ksq &&
			coef_index < zpc_pkg::KIDX_W'(zpc_pkg::KTAPS))
			cf_mem[coef_index] <= coef_value;
		coef_s1 <= cf_mem[k_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cf_vld_q <= '0;
		end else if (in_accept && action == zpc_pkg::ACT_COEF && coef_index < ksq &&
			coef_index < zpc_pkg::KIDX_W'(zpc_pkg::KTAPS)) begin
			cf_vld_q[coef_index] <= 1'b1;
		end
	end

	// window and tap sequencing
	always_ff @(posedge clk) begin
		if (pix_accept) begin
			ctx_py_q   <= py;
			ctx_slot_q <= pslot;
			oy_q    <= (py >= zpc_pkg::ROW_W'(r_eff)) ? py - zpc_pkg::ROW_W'(r_eff) : '0;
			oy_hi_q <= last_row ? py : py - zpc_pkg::ROW_W'(r_eff);
			ox_q    <= (px >= zpc_pkg::COL_W'(r_eff)) ? px - zpc_pkg::COL_W'(r_eff) : '0;
			ox_lo_q <= (px >= zpc_pkg::COL_W'(r_eff)) ? px - zpc_pkg::COL_W'(r_eff) : '0;
			ox_hi_q <= last_col ? px : px - zpc_pkg::COL_W'(r_eff);
			kyi_q <= '0;
			kxi_q <= '0;
			k_q   <= '0;
		end else if (cmd.out_load) begin
			if (ox_q == ox_hi_q) begin
				ox_q <= ox_lo_q;
				oy_q <= oy_q + 1'b1;
			end else begin
				ox_q <= ox_q + 1'b1;
			end
			kyi_q <= '0;
			kxi_q <= '0;
			k_q   <= '0;
		end else if (cmd.tap_issue) begin
			if (kxi_q == side_m1) begin
				kxi_q <= '0;
				kyi_q <= kyi_q + 1'b1;
			end else begin
				kxi_q <= kxi_q + 1'b1;
			end
			k_q <= k_q + 1'b1;
		end
	end

	// multiply-accumulate pipeline
	always_ff @(posedge clk) begin
		ok_s1   <= tap_ok;
		cvld_s1 <= cf_vld_q[k_q];
		last_s1 <= tap_last;
		last_s2 <= last_s1;
		if (ok_s1 && cvld_s1) prod_s2 <= coef_s1 * pix_s1;
		else prod_s2 <= '0;
		if (pix_accept || cmd.out_load) acc_q <= '0;
		else if (vld_s2) acc_q <= acc_q + zpc_pkg::ACC_W'(prod_s2);
		if (cmd.out_load) begin
			filtered_value <= acc_q;
			out_column     <= ox_q;
			out_row        <= oy_q;
			last           <= win_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			acc_done_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			vld_s1 <= cmd.tap_issue;
			vld_s2 <= vld_s1;
			if (cmd.out_load) acc_done_q <= 1'b0;
			else if (vld_s2 && last_s2) acc_done_q <= 1'b1;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		status.win_any  = x_ok && y_ok;
		status.tap_last = tap_last;
		status.acc_done = acc_done_q;
		status.out_free = !out_valid_q || out_ready;
		status.win_last = win_last;
		out_valid       = out_valid_q;
	end
endmodule

`default_nettype wire

// ===== hw/rtl/zero_padded_2d_convolution.sv =====
// Top level of the zero padded 2D convolution block.
// Instantiates zpc_ctrl and zpc_datapath; uses zpc_pkg and the defines header.
//
//   channel   handshake              payload
//   input     in_valid / in_ready    action, coef_index, coef_value, pixel_value
//   output    out_valid / out_ready  filtered_value, out_column, out_row, last
//   config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A coefficient load or a pixel that completes no window leaves the block idle.
// Each result runs (2r+1)^2 taps through the single shared multiply-accumulate
// unit, then drains the pipeline; input is held off while a pixel's results run.
// Reset marks coefficients unloaded (read as zero); the line memory needs no clear.
// A stalled output holds the next result in the accumulator until taken.
`timescale 1ns / 1ps
`default_nettype none
`include "zero_padded_2d_convolution_defines.svh"

module zero_padded_2d_convolution (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   in_valid,
	output logic                                  in_ready,
	input  wire                                   action,
	input  wire [zpc_pkg::KIDX_W-1:0]             coef_index,
	input  wire signed [zpc_pkg::COEF_W-1:0]      coef_value,
	input  wire signed [zpc_pkg::PIX_W-1:0]       pixel_value,
	output logic                                  out_valid,
	input  wire                                   out_ready,
	output logic signed [zpc_pkg::ACC_W-1:0]      filtered_value,
	output logic [zpc_pkg::COL_W-1:0]             out_column,
	output logic [zpc_pkg::ROW_W-1:0]             out_row,
	output logic                                  last,
	input  wire                                   cfg_valid,
	output logic                                  cfg_ready,
	input  wire [zpc_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  wire [zpc_pkg::CFG_DATA_W-1:0]         cfg_data
);
	zpc_pkg::cmd_t    cmd;
	zpc_pkg::status_t status;
	logic idle, in_accept, cfg_we;

	assign in_ready  = idle;
	// a pending input request goes first
	assign cfg_ready = idle && !in_valid;
	assign in_accept = in_valid && in_ready;
	assign cfg_we    = cfg_valid && cfg_ready;

	zpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_accept (in_accept),
		.action    (action),
		.status    (status),
		.cmd       (cmd),
		.idle      (idle)
	);

	zpc_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_accept      (in_accept),
		.action         (action),
		.coef_index     (coef_index),
		.coef_value     (coef_value),
		.pixel_value    (pixel_value),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.cmd            (cmd),
		.status         (status),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.filtered_value (filtered_value),
		.out_column     (out_column),
		.out_row        (out_row),
		.last           (last)
	);

	`ZPC_ASSERT_SAME(a_idle_pending_is_last, in_ready && out_valid, last)
	`ZPC_ASSERT_NEXT(a_coef_load_stays_idle, in_accept && action == zpc_pkg::ACT_COEF, in_ready)
	`ZPC_ASSERT_SAME(a_no_load_while_blocked, cmd.out_load, !out_valid || out_ready)
endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for zero_padded_2d_convolution.
// Depends on zpc_pkg and the block's RTL. It predicts every result of each accepted
// request and checks the results as they arrive, under random idling on both channels.
`timescale 1ns / 1ps

class conv_scoreboard;
	typedef struct {
		logic [38:0] value;
		logic [9:0]  col;
		logic [11:0] row;
		logic        last;
	} conv_result_t;

	logic signed [17:0] kernel[49];
	logic signed [15:0] lines[7*1024];
	int unsigned width_reg, height_reg, radius_reg;
	int col_pos, row_pos;
	conv_result_t expected_q[$];
	int errors, results_seen, requests_seen;

	function new();
		foreach (kernel[i]) kernel[i] = '0;
		foreach (lines[i]) lines[i] = '0;
		width_reg = 1024;
		height_reg = 1024;
		radius_reg = 1;
		col_pos = 0;
		row_pos = 0;
	endfunction

	function void write_reg(logic [1:0] idx, logic [12:0] data);
		case (idx)
			zpc_pkg::REG_WIDTH: width_reg = data & 13'h7FF;
			zpc_pkg::REG_HEIGHT: height_reg = data;
			zpc_pkg::REG_RADIUS: radius_reg = data & 13'h3;
			default: return;
		endcase
		col_pos = 0;
		row_pos = 0;
	endfunction

	function longint window_sum(int oy, int ox, int r, int w, int h);
		longint acc;
		int k;
		acc = 0;
		for (int ky = -r; ky <= r; ky++) begin
			for (int kx = -r; kx <= r; kx++) begin
				k = (ky + r) * (2 * r + 1) + (kx + r);
				if (oy + ky >= 0 && oy + ky < h && ox + kx >= 0 && ox + kx < w)
					acc += longint'(kernel[k]) * longint'(lines[((oy + ky) % 7) * 1024 + ox + kx]);
			end
		end
		return acc;
	endfunction

	// Accepted request: update state and queue every result it completes.
	function void note_request(logic act, logic [5:0] idx, logic signed [17:0] cv,
			logic signed [15:0] pv);
		int w, h, r, ylo, yhi, xlo, xhi, n;
		conv_result_t res;
		longint acc;
		w = (width_reg == 0) ? 1 : (width_reg > 1024 ? 1024 : width_reg);
		h = (height_reg == 0) ? 1 : (height_reg > 4096 ? 4096 : height_reg);
		r = radius_reg > 3 ? 3 : radius_reg;
		requests_seen++;
		if (act == zpc_pkg::ACT_COEF) begin
			if (idx < (2 * r + 1) * (2 * r + 1))
				kernel[idx] = cv;
			return;
		end
		if (col_pos >= w) col_pos = 0;
		if (row_pos >= h) row_pos = 0;
		lines[(row_pos % 7) * 1024 + col_pos] = pv;
		ylo = row_pos - r;
		yhi = ylo;
		if (row_pos == h - 1) begin
			ylo = ylo < 0 ? 0 : ylo;
			yhi = h - 1;
		end
		xlo = col_pos - r;
		xhi = xlo;
		if (col_pos == w - 1) begin
			xlo = xlo < 0 ? 0 : xlo;
			xhi = w - 1;
		end
		n = 0;
		if (ylo >= 0 && xlo >= 0) begin
			for (int oy = ylo; oy <= yhi; oy++) begin
				for (int ox = xlo; ox <= xhi; ox++) begin
					acc = window_sum(oy, ox, r, w, h);
					res.value = acc[38:0];
					res.col = 10'(ox);
					res.row = 12'(oy);
					res.last = 1'b0;
					expected_q.push_back(res);
					n++;
				end
			end
			if (n > 0) expected_q[$].last = 1'b1;
		end
		if (col_pos + 1 >= w) begin
			col_pos = 0;
			row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
		end else begin
			col_pos++;
		end
	endfunction

	task report(string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		errors++;
	endtask

	task check_result(logic [38:0] value, logic [9:0] col, logic [11:0] row, logic last);
		conv_result_t e;
		results_seen++;
		if (expected_q.size() == 0) begin
			report($sformatf("unexpected result row %0d col %0d", row, col));
			return;
		end
		e = expected_q.pop_front();
		if (value !== e.value)
			report($sformatf("value at (%0d,%0d): got %0d want %0d", e.row, e.col,
				$signed(value), $signed(e.value)));
		if (col !== e.col)
			report($sformatf("column: got %0d want %0d", col, e.col));
		if (row !== e.row)
			report($sformatf("row: got %0d want %0d", row, e.row));
		if (last !== e.last)
			report($sformatf("last at (%0d,%0d): got %0b want %0b", e.row, e.col,
				last, e.last));
	endtask
endclass

module testbench;
	localparam logic [zpc_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int IDLE_CYCLES = 80;
	localparam int STALL_LIMIT = 40000;
	localparam int ITEM_TARGET = 130;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic action = zpc_pkg::ACT_PIXEL;
	logic [zpc_pkg::KIDX_W-1:0] coef_index = '0;
	logic signed [zpc_pkg::COEF_W-1:0] coef_value = '0;
	logic signed [zpc_pkg::PIX_W-1:0] pixel_value = '0;
	logic out_ready = 1'b0;
	logic cfg_valid = 1'b0;
	logic [zpc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [zpc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	wire in_ready, out_valid, last, cfg_ready;
	wire signed [zpc_pkg::ACC_W-1:0] filtered_value;
	wire [zpc_pkg::COL_W-1:0] out_column;
	wire [zpc_pkg::ROW_W-1:0] out_row;

	conv_scoreboard sb = new();
	int send_idle = 0;
	int recv_stall = 0;
	int quiet_cycles = 0;
	int phases = 0;

	zero_padded_2d_convolution u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .coef_index(coef_index),
		.coef_value(coef_value), .pixel_value(pixel_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.filtered_value(filtered_value), .out_column(out_column),
		.out_row(out_row), .last(last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall);
	end

	// monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_request(action, coef_index, coef_value, pixel_value);
			if (out_valid && out_ready)
				sb.check_result(filtered_value, out_column, out_row, last);
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("timeout: %0d results still expected", sb.expected_q.size());
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	task set_idling(int mode);
		case (mode % 4)
			0: begin send_idle = 0; recv_stall = 0; end
			1: begin send_idle = 48; recv_stall = 0; end
			2: begin send_idle = 0; recv_stall = 48; end
			default: begin send_idle = 27; recv_stall = 27; end
		endcase
	endtask

	task send_request(logic act, logic [5:0] idx, logic [17:0] cv, logic [15:0] pv);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		coef_index <= idx;
		coef_value <= cv;
		pixel_value <= pv;
		do @(posedge clk); while (!in_ready);
	endtask

	task send_coef(int idx, logic [17:0] cv);
		send_request(zpc_pkg::ACT_COEF, 6'(idx), cv, 16'($urandom_range(0, 65535)));
	endtask

	task send_pixel(logic [15:0] pv);
		send_request(zpc_pkg::ACT_PIXEL, 6'($urandom_range(0, 63)),
			18'($urandom_range(0, 262143)), pv);
	endtask

	// hold off input until every expected result has come, then let the block settle
	task drain;
		in_valid <= 1'b0;
		while (sb.expected_q.size() > 0) @(posedge clk);
		repeat (IDLE_CYCLES) @(posedge clk);
	endtask

	task write_reg(logic [zpc_pkg::CFG_IDX_W-1:0] idx, logic [zpc_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task configure(int w, int h, int r);
		drain;
		write_reg(zpc_pkg::REG_WIDTH, zpc_pkg::CFG_DATA_W'(w));
		write_reg(zpc_pkg::REG_HEIGHT, zpc_pkg::CFG_DATA_W'(h));
		write_reg(zpc_pkg::REG_RADIUS, zpc_pkg::CFG_DATA_W'(r));
		phases++;
	endtask

	function logic [17:0] rand_coef();
		case ($urandom_range(0, 5))
			0: return 18'h20000;
			1: return 18'h1FFFF;
			default: return 18'($urandom_range(0, 262143));
		endcase
	endfunction

	function logic [15:0] rand_pixel();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	task load_kernel(int r);
		for (int k = 0; k < (2 * r + 1) * (2 * r + 1) && sb.requests_seen < ITEM_TARGET; k++)
			send_coef(k, rand_coef());
	endtask

	initial begin
		int w, h, r, npix;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, ignored loads, small frame
		set_idling(0);
		configure(4, 3, 1);
		send_coef(0, 18'h20000);
		send_coef(8, 18'h1FFFF);
		send_coef(4, 18'h10000);
		send_coef(9, 18'h1FFFF);
		send_coef(63, 18'h20000);
		send_pixel(16'h8000);
		send_pixel(16'h7FFF);
		for (int i = 0; i < 10; i++) send_pixel(i[0] ? 16'h7FFF : 16'h8000);
		// zero width and oversize height, radius 3 with stale coefficients
		configure(0, 8191, 3);
		for (int i = 0; i < 5; i++) send_pixel(rand_pixel());
		// oversize width, zero height, radius 0
		configure(2047, 0, 0);
		for (int i = 0; i < 4; i++) send_pixel(rand_pixel());
		drain;
		write_reg(REG_SPARE, 13'h1FFF);
		send_pixel(16'h1234);

		// random frames; idling mode steps with the request count
		while (sb.requests_seen < ITEM_TARGET) begin
			set_idling(sb.requests_seen / 25);
			w = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
			h = $urandom_range(1, 5);
			r = $urandom_range(0, 3);
			configure(w, h, r);
			if ($urandom_range(0, 3) != 0)
				load_kernel(r);
			else
				for (int i = 0; i < 3; i++) send_coef($urandom_range(0, 63), rand_coef());
			npix = w * h + $urandom_range(0, w);
			for (int i = 0; i < npix && sb.requests_seen < ITEM_TARGET; i++) begin
				set_idling(sb.requests_seen / 25);
				send_pixel(rand_pixel());
				if (i == npix / 2 && phases % 3 == 0) drain;
				if ($urandom_range(0, 19) == 0)
					send_coef($urandom_range(0, 63), rand_coef());
			end
		end

		drain;
		$display("run covered %0d requests, %0d results, %0d register settings",
			sb.requests_seen, sb.results_seen, phases);
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/zpc_pkg.sv
hw/rtl/zpc_ctrl.sv
hw/rtl/zpc_datapath.sv
hw/rtl/zero_padded_2d_convolution.sv
tb/testbench.sv
